@@ rtl/wsta_pkg.sv @@
// shared types, constants and codes of the weighted server task assigner
package wsta_pkg;

	// table size and field widths
	localparam int MAX_SERVERS = 16;
	localparam int IDX_W       = $clog2(MAX_SERVERS);
	localparam int CNT_W       = 5;
	localparam int SLOT_W      = 4;
	localparam int WGT_W       = 20;
	localparam int DUR_W       = 20;
	localparam int TIME_W      = 40;
	localparam int OIDX_W      = 4;
	localparam int CMD_W       = 2;

	localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(16);
	localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

	// command codes carried on tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ASSIGN  = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} st_t;

	// one table entry as it comes back from the memories
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [WGT_W-1:0]  weight;
		logic [TIME_W-1:0] ft;
	} scan_ent_t;

	// outcome of a scan: chosen server and the time its new job starts from
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] base;
	} pick_res_t;

endpackage

@@ rtl/wsta_ram.sv @@
// generic single write port, single read port ram with registered read data
module wsta_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/wsta_pick.sv @@
// running selection over the scanned entries: best free server and earliest busy one
module wsta_pick (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  wsta_pkg::scan_ent_t        ent,
	input  logic [wsta_pkg::TIME_W-1:0] now,
	output wsta_pkg::pick_res_t        res
);

	logic                          ff_q;
	logic [wsta_pkg::IDX_W-1:0]    fidx_q;
	logic [wsta_pkg::WGT_W-1:0]    fw_q;
	logic                          first_q;
	logic [wsta_pkg::IDX_W-1:0]    aidx_q;
	logic [wsta_pkg::WGT_W-1:0]    aw_q;
	logic [wsta_pkg::TIME_W-1:0]   aft_q;
	logic                          take_f;
	logic                          take_a;

	// compare the incoming entry against both running bests
	always_comb begin
		take_f = ent.valid && (ent.ft <= now) && (!ff_q || (ent.weight < fw_q));
		take_a = ent.valid && (first_q || (ent.ft < aft_q) ||
			((ent.ft == aft_q) && (ent.weight < aw_q)));
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q    <= 1'b0;
			first_q <= 1'b1;
		end else if (start) begin
			ff_q    <= 1'b0;
			first_q <= 1'b1;
		end else begin
			if (take_f) begin
				ff_q <= 1'b1;
			end
			if (ent.valid) begin
				first_q <= 1'b0;
			end
		end
	end

	// candidate payload
	always_ff @(posedge clk) begin
		if (take_f) begin
			fidx_q <= ent.idx;
			fw_q   <= ent.weight;
		end
		if (take_a) begin
			aidx_q <= ent.idx;
			aw_q   <= ent.weight;
			aft_q  <= ent.ft;
		end
	end

	// a free server wins over the earliest busy one
	always_comb begin
		res.idx  = ff_q ? fidx_q : aidx_q;
		res.base = ff_q ? now : aft_q;
	end

endmodule

@@ rtl/weighted_server_task_assigner.sv @@
// weighted server task assigner: assign tasks to servers by free time and weight
// a task word scans the table entries of the servers in use, then the chosen result is registered
// no new word is accepted until the scan is through and its result has entered the output register
// load and restart words give no result
// reset: free times and task clock cleared, server count 16, weights undefined until loaded
// the output register lets the next word enter while a result waits to be taken
module weighted_server_task_assigner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,   // server_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,       // server_slot[3:0], weight[23:4], duration[43:24], zero
	input  logic [1:0]  s_tuser,       // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata        // assigned_server[3:0], finish_time[43:4], zero
);

	localparam int IW = wsta_pkg::IDX_W;
	localparam int TW = wsta_pkg::TIME_W;

	wsta_pkg::st_t      st_q, st_d;
	wsta_pkg::cmd_t     cmd;
	wsta_pkg::scan_ent_t ent;
	wsta_pkg::pick_res_t res;

	logic [wsta_pkg::CNT_W-1:0]  cfg_q;
	logic [IW-1:0]               last_q;
	logic [IW-1:0]               last_d;
	logic [IW-1:0]               addr_q;
	logic                        rv_s1;
	logic [IW-1:0]               ridx_s1;
	logic [wsta_pkg::MAX_SERVERS-1:0] fvalid_q;
	logic [TW-1:0]               clk_q;
	logic [wsta_pkg::DUR_W-1:0]  dur_q;
	logic                        ov_q;
	logic [wsta_pkg::OIDX_W-1:0] oidx_q;
	logic [TW-1:0]               oft_q;

	logic [wsta_pkg::SLOT_W-1:0] slot;
	logic [wsta_pkg::WGT_W-1:0]  wgt;
	logic [wsta_pkg::DUR_W-1:0]  dur;
	logic                        acc;
	logic                        acc_assign;
	logic                        acc_restart;
	logic                        w_we;
	logic                        fire;
	logic [TW:0]                 sum;
	logic [TW-1:0]               new_ft;
	logic [TW-1:0]               ft_rd;
	logic [wsta_pkg::WGT_W-1:0]  w_rd;

	// input word fields
	always_comb begin
		cmd  = wsta_pkg::cmd_t'(s_tuser);
		slot = s_tdata[3:0];
		wgt  = s_tdata[23:4];
		dur  = s_tdata[43:24];
	end

	assign s_tready    = (st_q == wsta_pkg::ST_IDLE);
	assign acc         = s_tvalid && s_tready;
	assign acc_assign  = acc && (cmd == wsta_pkg::CMD_ASSIGN);
	assign acc_restart = acc && (cmd == wsta_pkg::CMD_RESTART);
	assign w_we        = acc && (cmd == wsta_pkg::CMD_LOAD) &&
		(32'(slot) < wsta_pkg::MAX_SERVERS);

	// last index in use, count clamped to one .. table size
	always_comb begin
		if (cfg_q == '0) begin
			last_d = '0;
		end else if (32'(cfg_q) > wsta_pkg::MAX_SERVERS) begin
			last_d = IW'(wsta_pkg::MAX_SERVERS - 1);
		end else begin
			last_d = IW'(cfg_q - 1'b1);
		end
	end

	// saturating finish time of the chosen server
	always_comb begin
		sum    = {1'b0, res.base} + (TW+1)'(dur_q);
		new_ft = sum[TW] ? wsta_pkg::TIME_MAX : sum[TW-1:0];
	end

	assign fire = (st_q == wsta_pkg::ST_DONE) && (!ov_q || m_tready);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= wsta_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			wsta_pkg::ST_IDLE: begin
				if (acc_assign) begin
					st_d = wsta_pkg::ST_SCAN;
				end
			end
			wsta_pkg::ST_SCAN: begin
				if (addr_q == last_q) begin
					st_d = wsta_pkg::ST_LAST;
				end
			end
			wsta_pkg::ST_LAST: begin
				st_d = wsta_pkg::ST_DONE;
			end
			wsta_pkg::ST_DONE: begin
				if (fire) begin
					st_d = wsta_pkg::ST_IDLE;
				end
			end
			default: st_d = wsta_pkg::ST_IDLE;
		endcase
	end

	// configuration, task clock, scan address and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= wsta_pkg::CNT_RESET;
			clk_q    <= '0;
			addr_q   <= '0;
			rv_s1    <= 1'b0;
			fvalid_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			rv_s1 <= (st_q == wsta_pkg::ST_SCAN);
			if (acc_assign) begin
				addr_q <= '0;
			end else if ((st_q == wsta_pkg::ST_SCAN) && (addr_q != last_q)) begin
				addr_q <= addr_q + 1'b1;
			end
			if (acc_restart) begin
				fvalid_q <= '0;
				clk_q    <= '0;
			end else if (fire) begin
				fvalid_q[res.idx] <= 1'b1;
				if (clk_q != wsta_pkg::TIME_MAX) begin
					clk_q <= clk_q + 1'b1;
				end
			end
		end
	end

	// task payload and read index pipeline
	always_ff @(posedge clk) begin
		if (acc_assign) begin
			last_q <= last_d;
			dur_q  <= dur;
		end
		ridx_s1 <= addr_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (fire) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			oidx_q <= wsta_pkg::OIDX_W'(res.idx);
			oft_q  <= new_ft;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {4'b0, oft_q, oidx_q};

	// weight table
	wsta_ram #(
		.DEPTH (wsta_pkg::MAX_SERVERS),
		.WIDTH (wsta_pkg::WGT_W)
	) u_wgt (
		.clk   (clk),
		.we    (w_we),
		.waddr (IW'(slot)),
		.wdata (wgt),
		.raddr (addr_q),
		.rdata (w_rd)
	);

	// free time table, entries not yet written since restart read as zero
	wsta_ram #(
		.DEPTH (wsta_pkg::MAX_SERVERS),
		.WIDTH (TW)
	) u_ft (
		.clk   (clk),
		.we    (fire),
		.waddr (res.idx),
		.wdata (new_ft),
		.raddr (addr_q),
		.rdata (ft_rd)
	);

	// entry handed to the selection unit
	always_comb begin
		ent.valid  = rv_s1;
		ent.idx    = ridx_s1;
		ent.weight = w_rd;
		ent.ft     = fvalid_q[ridx_s1] ? ft_rd : '0;
	end

	wsta_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc_assign),
		.ent    (ent),
		.now    (clk_q),
		.res    (res)
	);

	// scan stays within the servers in use
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == wsta_pkg::ST_SCAN) |-> (addr_q <= last_q))
		else $error("scan address beyond last server");

	// written back server lies within the servers in use
	a_pick_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (res.idx <= last_q))
		else $error("chosen server out of range");

	// a new free time never lies before the task clock
	a_ft_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (new_ft >= clk_q))
		else $error("finish time before task clock");

	// restart clears every free time
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc_restart |=> ((fvalid_q == '0) && (clk_q == '0)))
		else $error("restart left state behind");

endmodule
